// ===== hw/rtl/acpr_pkg.sv =====
// Shared types, constants and helpers for the ARP cache with pending-packet release.
// Used by acpr_ctrl, acpr_dp, arp_cache_pending_release_core and acpr_checker.
`default_nettype none

package acpr_pkg;

    localparam int CACHE_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF   = 32;
    localparam int NUM_PORTS         = 4;

    typedef enum logic [2:0] {
        KIND_HIT      = 3'd0,
        KIND_QUEUED   = 3'd1,
        KIND_DROPPED  = 3'd2,
        KIND_STORED   = 3'd3,
        KIND_FULL     = 3'd4,
        KIND_RELEASED = 3'd5
    } kind_t;

    typedef struct packed {
        logic        action;
        logic [31:0] next_hop_ip;
        logic [1:0]  port;
        logic [9:0]  packet_tag;
        logic [47:0] sender_mac;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  out_tag;
        logic [1:0]  out_port;
        logic [31:0] target_ip;
        logic [47:0] dest_mac;
        logic        last;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EMIT,
        ST_STORE,
        ST_CNT,
        ST_HEAD,
        ST_RREAD,
        ST_RCHK
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  load;
        logic  look_step;
        logic  store;
        logic  push;
        logic  cnt_step;
        logic  rel_init;
        logic  rel_read;
        logic  rel_adv;
        logic  rel_keep;
        logic  commit;
        logic  emit;
        kind_t kind;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic action;
        logic look_hit;
        logic look_done;
        logic q_full;
        logic c_full;
        logic cnt_done;
        logic rel_zero;
        logic q_end;
        logic rel_match;
        logic out_free;
    } stat_t;

    // Reduce an interface number modulo NUM_PORTS (input is below four)
    function automatic logic [1:0] port_mod(input logic [1:0] p);
        logic [8:0] r;
        r = {7'd0, p};
        for (int k = 0; k < 3; k++) begin
            if (r >= 9'(NUM_PORTS))
            begin
                r = r - 9'(NUM_PORTS);
            end
        end
        return r[1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acpr_ctrl.sv =====
// Controller state machine for the ARP cache with pending-packet release.
// Depends on acpr_pkg; drives acpr_dp through cmd_t and reads stat_t.
`default_nettype none

module acpr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire acpr_pkg::stat_t st,
    output acpr_pkg::cmd_t       cmd
);

    acpr_pkg::state_t state_reg, state_next;
    acpr_pkg::kind_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acpr_pkg::ST_IDLE;
            kind_reg  <= acpr_pkg::KIND_HIT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        req_stall  = 1'b1;
        unique case (state_reg)
            acpr_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.action ? acpr_pkg::ST_STORE : acpr_pkg::ST_LOOK;
                end
            end
            acpr_pkg::ST_LOOK:
            begin
                cmd.look_step = 1'b1;
                if (st.look_hit)
                begin
                    kind_next  = acpr_pkg::KIND_HIT;
                    state_next = acpr_pkg::ST_EMIT;
                end
                else if (st.look_done)
                begin
                    kind_next  = st.q_full ? acpr_pkg::KIND_DROPPED : acpr_pkg::KIND_QUEUED;
                    state_next = acpr_pkg::ST_EMIT;
                end
            end
            acpr_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.push   = (kind_reg == acpr_pkg::KIND_QUEUED);
                    state_next = acpr_pkg::ST_IDLE;
                end
            end
            acpr_pkg::ST_STORE:
            begin
                cmd.store  = 1'b1;
                kind_next  = st.c_full ? acpr_pkg::KIND_FULL : acpr_pkg::KIND_STORED;
                state_next = acpr_pkg::ST_CNT;
            end
            acpr_pkg::ST_CNT:
            begin
                cmd.cnt_step = 1'b1;
                if (st.cnt_done)
                begin
                    state_next = acpr_pkg::ST_HEAD;
                end
            end
            acpr_pkg::ST_HEAD:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.rel_init = 1'b1;
                    state_next   = st.rel_zero ? acpr_pkg::ST_IDLE : acpr_pkg::ST_RREAD;
                end
            end
            acpr_pkg::ST_RREAD:
            begin
                if (st.q_end)
                begin
                    cmd.commit = 1'b1;
                    state_next = acpr_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rel_read = 1'b1;
                    state_next   = acpr_pkg::ST_RCHK;
                end
            end
            acpr_pkg::ST_RCHK:
            begin
                if (st.rel_match)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.kind    = acpr_pkg::KIND_RELEASED;
                        cmd.rel_adv = 1'b1;
                        state_next  = acpr_pkg::ST_RREAD;
                    end
                end
                else
                begin
                    cmd.rel_keep = 1'b1;
                    state_next   = acpr_pkg::ST_RREAD;
                end
            end
            default:
            begin
                state_next = acpr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/acpr_dp.sv =====
// Datapath: address table, wait queue, scan counters and result register.
// Depends on acpr_pkg; commanded by acpr_ctrl.
`default_nettype none

module acpr_dp #(
    parameter int CACHE_ENTRIES = acpr_pkg::CACHE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = acpr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire acpr_pkg::in_t  req_data,
    input  wire logic           rsp_stall,
    output logic                rsp_valid,
    output acpr_pkg::out_t      rsp_data,
    input  wire acpr_pkg::cmd_t cmd,
    output acpr_pkg::stat_t     st
);

    localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CCW = $clog2(CACHE_ENTRIES + 1);
    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } cent_t;

    typedef struct packed {
        logic [31:0] hop;
        logic [1:0]  port;
        logic [9:0]  tag;
    } qent_t;

    cent_t cmem [CACHE_ENTRIES];
    qent_t qmem [QUEUE_DEPTH];
    cent_t c_rd_reg;
    qent_t q_rd_reg;

    logic [31:0] ip_reg;
    logic [1:0]  port_reg;
    logic [9:0]  tag_reg;
    logic [47:0] mac_reg;

    logic [CCW-1:0] ccount_reg, ccount_next;
    logic [CCW-1:0] cptr_reg, cptr_next;
    logic           cpend_reg, cpend_next;
    logic [QCW-1:0] wcount_reg, wcount_next;
    logic [QCW-1:0] qptr_reg, qptr_next;
    logic           qpend_reg, qpend_next;
    logic [QCW-1:0] keep_reg, keep_next;
    logic [QCW-1:0] rel_reg, rel_next;
    logic           out_valid_reg, out_valid_next;
    acpr_pkg::out_t out_reg, out_next;

    logic c_re, c_we, q_re, q_we;
    logic [CIW-1:0] c_raddr;
    logic [QIW-1:0] q_raddr, q_waddr;
    qent_t q_wdata;
    logic look_hit, cnt_hit, c_full, q_full;

    assign c_full   = (ccount_reg == CCW'(CACHE_ENTRIES));
    assign q_full   = (wcount_reg == QCW'(QUEUE_DEPTH));
    assign look_hit = cpend_reg && (c_rd_reg.ip == ip_reg);
    assign cnt_hit  = qpend_reg && (q_rd_reg.hop == ip_reg);

    assign st.action    = req_data.action;
    assign st.look_hit  = look_hit;
    assign st.look_done = !cpend_reg && (cptr_reg == ccount_reg);
    assign st.q_full    = q_full;
    assign st.c_full    = c_full;
    assign st.cnt_done  = !qpend_reg && (qptr_reg == wcount_reg);
    assign st.rel_zero  = (rel_reg == '0);
    assign st.q_end     = (qptr_reg == wcount_reg);
    assign st.rel_match = (q_rd_reg.hop == ip_reg);
    assign st.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        ccount_next    = ccount_reg;
        cptr_next      = cptr_reg;
        cpend_next     = cpend_reg;
        wcount_next    = wcount_reg;
        qptr_next      = qptr_reg;
        qpend_next     = qpend_reg;
        keep_next      = keep_reg;
        rel_next       = rel_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        c_re    = 1'b0;
        c_we    = 1'b0;
        q_re    = 1'b0;
        q_we    = 1'b0;
        c_raddr = cptr_reg[CIW-1:0];
        q_raddr = qptr_reg[QIW-1:0];
        q_waddr = wcount_reg[QIW-1:0];
        q_wdata = '{hop: ip_reg, port: port_reg, tag: tag_reg};

        if (cmd.load)
        begin
            cptr_next  = '0;
            cpend_next = 1'b0;
            qptr_next  = '0;
            qpend_next = 1'b0;
            rel_next   = '0;
        end

        // Pipelined table walk: compare the entry read last cycle, fetch the next
        if (cmd.look_step && !look_hit)
        begin
            if (cptr_reg != ccount_reg)
            begin
                c_re       = 1'b1;
                cptr_next  = cptr_reg + CCW'(1);
                cpend_next = 1'b1;
            end
            else
            begin
                cpend_next = 1'b0;
            end
        end

        if (cmd.store && !c_full)
        begin
            c_we        = 1'b1;
            ccount_next = ccount_reg + CCW'(1);
        end

        if (cmd.push && !q_full)
        begin
            q_we        = 1'b1;
            wcount_next = wcount_reg + QCW'(1);
        end

        // Count queued packets for this hop before the head result goes out
        if (cmd.cnt_step)
        begin
            if (cnt_hit)
            begin
                rel_next = rel_reg + QCW'(1);
            end
            if (qptr_reg != wcount_reg)
            begin
                q_re       = 1'b1;
                qptr_next  = qptr_reg + QCW'(1);
                qpend_next = 1'b1;
            end
            else
            begin
                qpend_next = 1'b0;
            end
        end

        if (cmd.rel_init)
        begin
            qptr_next = '0;
            keep_next = '0;
        end

        if (cmd.rel_read)
        begin
            q_re = 1'b1;
        end

        if (cmd.rel_adv)
        begin
            qptr_next = qptr_reg + QCW'(1);
            rel_next  = rel_reg - QCW'(1);
        end

        // Compact survivors toward the head, order kept
        if (cmd.rel_keep)
        begin
            q_we      = 1'b1;
            q_waddr   = keep_reg[QIW-1:0];
            q_wdata   = q_rd_reg;
            keep_next = keep_reg + QCW'(1);
            qptr_next = qptr_reg + QCW'(1);
        end

        if (cmd.commit)
        begin
            wcount_next = keep_reg;
        end

        if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_valid_next     = 1'b1;
            out_next.kind      = cmd.kind;
            out_next.target_ip = ip_reg;
            unique case (cmd.kind)
                acpr_pkg::KIND_HIT:
                begin
                    out_next.out_tag  = tag_reg;
                    out_next.out_port = port_reg;
                    out_next.dest_mac = c_rd_reg.mac;
                    out_next.last     = 1'b1;
                end
                acpr_pkg::KIND_QUEUED, acpr_pkg::KIND_DROPPED:
                begin
                    out_next.out_tag  = tag_reg;
                    out_next.out_port = port_reg;
                    out_next.dest_mac = '0;
                    out_next.last     = 1'b1;
                end
                acpr_pkg::KIND_STORED, acpr_pkg::KIND_FULL:
                begin
                    out_next.out_tag  = '0;
                    out_next.out_port = '0;
                    out_next.dest_mac = mac_reg;
                    out_next.last     = (rel_reg == '0);
                end
                default:
                begin
                    out_next.out_tag  = q_rd_reg.tag;
                    out_next.out_port = q_rd_reg.port;
                    out_next.dest_mac = mac_reg;
                    out_next.last     = (rel_reg == QCW'(1));
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccount_reg    <= '0;
            cptr_reg      <= '0;
            cpend_reg     <= 1'b0;
            wcount_reg    <= '0;
            qptr_reg      <= '0;
            qpend_reg     <= 1'b0;
            keep_reg      <= '0;
            rel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ccount_reg    <= ccount_next;
            cptr_reg      <= cptr_next;
            cpend_reg     <= cpend_next;
            wcount_reg    <= wcount_next;
            qptr_reg      <= qptr_next;
            qpend_reg     <= qpend_next;
            keep_reg      <= keep_next;
            rel_reg       <= rel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.load)
        begin
            ip_reg     <= req_data.next_hop_ip;
            port_reg   <= acpr_pkg::port_mod(req_data.port);
            tag_reg    <= req_data.packet_tag;
            mac_reg    <= req_data.sender_mac;
        end
    end

    // Table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cmem[ccount_reg[CIW-1:0]] <= '{ip: ip_reg, mac: mac_reg};
        end
        if (c_re)
        begin
            c_rd_reg <= cmem[c_raddr];
        end
    end

    // Wait-queue memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_waddr] <= q_wdata;
        end
        if (q_re)
        begin
            q_rd_reg <= qmem[q_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/arp_cache_pending_release_core.sv =====
// ARP resolver with pending-packet queue: a resolve transaction (action 0) walks the
// address table in insertion order, one entry per cycle through a pipelined
// read of the table memory, over the stored entries (up to CACHE_ENTRIES); a hit
// forwards the packet with the first matching MAC, a miss asks for an ARP request
// and parks the packet in the wait queue, or drops it when the queue holds
// QUEUE_DEPTH packets. A reply transaction (action 1) appends (ip, mac) to the
// table unless it is full, counts the waiting packets for that hop in one pass
// over the queued entries, sends the stored/full result, and ends there when
// nothing waits for that hop. Otherwise it takes a second pass, a read state
// (ST_RREAD) and a check state (ST_RCHK) per queued entry, that releases matching
// packets in order and compacts the rest; each check follows the registered
// read of its queue entry. One transaction is in work at a time; the result
// register lets the next request be taken while the last result still waits on
// rsp_stall, and a transaction waits wherever it must emit a result while an
// earlier one still waits on rsp_stall. Interface numbers are folded modulo
// NUM_PORTS. Memories need no clearing pass; counts reset to zero.
// Depends on acpr_pkg, acpr_ctrl and acpr_dp.
`default_nettype none

module arp_cache_pending_release_core #(
    parameter int CACHE_ENTRIES = acpr_pkg::CACHE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = acpr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire acpr_pkg::in_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output acpr_pkg::out_t     rsp_data
);

    acpr_pkg::cmd_t  cmd;
    acpr_pkg::stat_t st;

    // Sequence each transaction
    acpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // Hold table, queue and result register
    acpr_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/acpr_checker.sv =====
// Port-level checks for arp_cache_pending_release_core, bound to the top level.
// Depends on acpr_pkg.
`default_nettype none

module acpr_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire acpr_pkg::out_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.kind == acpr_pkg::KIND_HIT ||
                      rsp_data.kind == acpr_pkg::KIND_QUEUED ||
                      rsp_data.kind == acpr_pkg::KIND_DROPPED) |-> rsp_data.last)
        else $error("resolve result not marked last");

    a_reply_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.kind == acpr_pkg::KIND_STORED ||
                      rsp_data.kind == acpr_pkg::KIND_FULL)
        |-> rsp_data.out_tag == '0 && rsp_data.out_port == '0)
        else $error("reply head carries tag or port");

    a_miss_mac: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.kind == acpr_pkg::KIND_QUEUED ||
                      rsp_data.kind == acpr_pkg::KIND_DROPPED) |-> rsp_data.dest_mac == '0)
        else $error("miss result carries a MAC");

endmodule

bind arp_cache_pending_release_core acpr_checker u_acpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire
